// ----- design/tsp_pkg.sv -----
// Package for the table search probe counter: sizes, codes and state type.
`default_nettype none
package tsp_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEN_W   = 11;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 11;
  localparam int FUNC_W  = 2;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_BINARY = 2'd1,
    FUNC_LINEAR = 2'd2,
    FUNC_NONE   = 2'd3
  } tsp_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK
  } tsp_state_e;

endpackage
`default_nettype wire

// ----- design/table_search_probe_counter_top.sv -----
// Table search probe counter: table memory plus binary and linear search sequencer.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------------
//  command  | func_i, entry_index_i, data_word_i            | start_i & !busy_o
//  config   | cfg_data_i (table_length)                     | cfg_valid_i & cfg_ready_o
//  result   | compare_count_o, matched_o                    | done_o, one cycle
//
//  A write item is stored and an unused func code is dropped, both from idle.
//  A query with table_length zero answers in the cycle after acceptance.
//  Other queries run each probe as a memory read, then a compare, so a
//  binary query needs up to log2(len)+1 probes and a linear one up to len.
//  done_o rises the cycle after the last compare, while busy_o is already low.
//  Reset clears control only; the table has no clearing pass. Results cannot stall.
`default_nettype none
module table_search_probe_counter_top
  import tsp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [FUNC_W-1:0]        func_i,
  input  wire logic [ADDR_W-1:0]        entry_index_i,
  input  wire logic signed [WORD_W-1:0] data_word_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [LEN_W-1:0]         cfg_data_i,
  output logic                          done_o,
  output logic [CNT_W-1:0]              compare_count_o,
  output logic                          matched_o
);

  tsp_state_e state_q, state_d;

  logic [LEN_W-1:0]         len_q;
  logic [LEN_W-1:0]         eff_len;
  logic [LEN_W-1:0]         lo_q, lo_d;     // low bound, or scan position
  logic [LEN_W-1:0]         hi_q, hi_d;     // exclusive high bound
  logic [CNT_W-1:0]         tally_q, tally_d;
  logic                     linear_q, linear_d;
  logic signed [WORD_W-1:0] target_q, target_d;
  logic                     done_q, done_d;
  logic                     hit_q, hit_d;
  logic [CNT_W-1:0]         count_q, count_d;

  logic [LEN_W:0]           mid_sum;
  logic [LEN_W-1:0]         mid;
  logic [LEN_W-1:0]         probe;
  logic [LEN_W-1:0]         lo_step, hi_step, probe_inc;
  logic [CNT_W-1:0]         tally_inc;
  logic                     accept, is_query, finish;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_q;
  logic                     mem_we;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign is_query    = (func_i == FUNC_BINARY) || (func_i == FUNC_LINEAR);
  assign eff_len     = (len_q > DEPTH_LEN) ? DEPTH_LEN : len_q;
  assign mem_we      = accept && (func_i == FUNC_WRITE) && (32'(entry_index_i) < DEPTH);

  // floor((lo + hi - 1) / 2); lo < hi holds whenever a probe is issued
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q} - {{LEN_W{1'b0}}, 1'b1};
  assign mid         = mid_sum[LEN_W:1];
  assign probe       = linear_q ? lo_q : mid;
  assign probe_inc   = probe + {{(LEN_W-1){1'b0}}, 1'b1};
  assign tally_inc   = (tally_q == CNT_MAX) ? tally_q : tally_q + {{(CNT_W-1){1'b0}}, 1'b1};

  // bounds after a mismatch at the current probe
  always_comb begin
    lo_step = lo_q;
    hi_step = hi_q;
    if (linear_q) begin
      lo_step = probe_inc;
    end else if (rd_q > target_q) begin
      hi_step = mid;
    end else begin
      lo_step = probe_inc;
    end
  end

  assign finish = (rd_q == target_q) || (lo_step >= hi_step);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_query && (eff_len != '0)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = finish ? ST_IDLE : ST_PROBE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    tally_d  = tally_q;
    linear_d = linear_q;
    target_d = target_q;
    done_d   = 1'b0;
    hit_d    = hit_q;
    count_d  = count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_query) begin
          lo_d     = '0;
          hi_d     = eff_len;
          tally_d  = '0;
          linear_d = (func_i == FUNC_LINEAR);
          target_d = data_word_i;
          if (eff_len == '0) begin
            done_d  = 1'b1;
            hit_d   = 1'b0;
            count_d = '0;
          end
        end
      end
      ST_PROBE: begin
      end
      ST_CHECK: begin
        if (rd_q == target_q) begin
          done_d  = 1'b1;
          hit_d   = 1'b1;
          count_d = tally_q;
        end else begin
          lo_d    = lo_step;
          hi_d    = hi_step;
          tally_d = tally_inc;
          if (lo_step >= hi_step) begin
            done_d  = 1'b1;
            hit_d   = 1'b0;
            count_d = tally_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      tally_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      tally_q <= tally_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    linear_q <= linear_d;
    target_q <= target_d;
    hit_q    <= hit_d;
    count_q  <= count_d;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[entry_index_i] <= data_word_i;
    end
    rd_q <= mem[probe[ADDR_W-1:0]];
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign cfg_ready_o     = !busy_o;
  assign done_o          = done_q;
  assign compare_count_o = count_q;
  assign matched_o       = hit_q;

  // a probe is only issued over a live range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (lo_q < hi_q))
    else $error("probe issued with empty range");

  // the live range never grows past the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (hi_q <= DEPTH_LEN))
    else $error("high bound beyond table");

  // a result follows either a compare or an empty query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_CHECK) || ($past(state_q) == ST_IDLE))
    else $error("result strobe without a finished search");

  // a found item reports fewer misses than the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && matched_o) |-> (compare_count_o < DEPTH_LEN))
    else $error("miss count too large on a hit");

endmodule
`default_nettype wire

// ----- tb/sv/table_search_probe_counter_top_tb.sv -----
// Self-checking testbench for the table search probe counter: directed and random items.
module table_search_probe_counter_top_tb;
  import tsp_pkg::*;

  localparam int QUIET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 32;
  localparam int TAIL_ITEMS   = 40;
  localparam int ITEM_TARGET  = 700;

  typedef struct packed {
    logic                     is_cfg;
    tsp_func_e                func;
    logic [ADDR_W-1:0]        idx;
    logic [WORD_W-1:0]        word;
    logic [LEN_W-1:0]         len;
  } search_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             matched;
  } search_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [FUNC_W-1:0]        func_i = '0;
  logic [ADDR_W-1:0]        entry_index_i = '0;
  logic signed [WORD_W-1:0] data_word_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic [LEN_W-1:0]         cfg_data_i = '0;
  logic                     busy_o;
  logic                     cfg_ready_o;
  logic                     done_o;
  logic [CNT_W-1:0]         compare_count_o;
  logic                     matched_o;

  table_search_probe_counter_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .data_word_i     (data_word_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .compare_count_o (compare_count_o),
    .matched_o       (matched_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  search_cmd_t              cmd_q[$];
  search_result_t           exp_results_q[$];

  // predictor state, updated as items are accepted
  logic signed [WORD_W-1:0] ref_tbl [DEPTH];
  logic [LEN_W-1:0]         ref_len = '0;

  // generator view of the table, updated as items are queued
  logic signed [WORD_W-1:0] gen_tbl [DEPTH];
  bit                       gen_written [DEPTH];
  int                       gen_items = 0;

  int                       err_cnt = 0;

  function automatic search_result_t predict_search(input tsp_func_e f,
                                                    input logic signed [WORD_W-1:0] target);
    search_result_t           r;
    int                       lo;
    int                       hi;
    int                       mid;
    int                       n;
    int                       i;
    logic signed [WORD_W-1:0] v;
    logic                     hit;
    n = (ref_len > DEPTH_LEN) ? DEPTH : int'(ref_len);
    r.count = '0;
    hit = 1'b0;
    if (f == FUNC_BINARY) begin
      lo = 0;
      hi = n;
      while (lo < hi && !hit) begin
        mid = (lo + hi - 1) >> 1;
        v = ref_tbl[mid];
        if (v == target) begin
          hit = 1'b1;
        end else begin
          if (v > target) hi = mid;
          else lo = mid + 1;
          if (r.count != CNT_MAX) r.count = r.count + 1'b1;
        end
      end
    end else begin
      for (i = 0; i < n && !hit; i++) begin
        if (ref_tbl[i] == target) hit = 1'b1;
        else if (r.count != CNT_MAX) r.count = r.count + 1'b1;
      end
    end
    r.matched = hit;
    return r;
  endfunction

  function automatic void apply_cmd(input search_cmd_t c);
    case (c.func)
      FUNC_WRITE: ref_tbl[c.idx] = c.word;
      FUNC_BINARY, FUNC_LINEAR: begin
        exp_results_q.push_back(predict_search(c.func, c.word));
      end
      default: ;
    endcase
  endfunction

  task automatic push_write(input int idx, input logic signed [WORD_W-1:0] word, input bit bulk);
    search_cmd_t c;
    c = '0;
    c.func = FUNC_WRITE;
    c.idx = ADDR_W'(idx);
    c.word = word;
    cmd_q.push_back(c);
    gen_tbl[idx] = word;
    gen_written[idx] = 1'b1;
    if (!bulk) gen_items++;
  endtask

  task automatic push_query(input tsp_func_e f, input logic signed [WORD_W-1:0] target);
    search_cmd_t c;
    c = '0;
    c.func = f;
    c.idx = ADDR_W'($urandom_range(0, DEPTH - 1));
    c.word = target;
    cmd_q.push_back(c);
    gen_items++;
  endtask

  task automatic push_noise();
    search_cmd_t c;
    c = '0;
    c.func = FUNC_NONE;
    c.idx = ADDR_W'($urandom_range(0, DEPTH - 1));
    c.word = $urandom();
    cmd_q.push_back(c);
  endtask

  task automatic push_cfg(input int len);
    search_cmd_t c;
    c = '0;
    c.is_cfg = 1'b1;
    c.len = LEN_W'(len);
    cmd_q.push_back(c);
  endtask

  // driver
  search_cmd_t cur_cmd;
  int          idle_left = 0;
  bit          idle_mode = 1'b1;
  int          quiet_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nx_start;
    logic nx_cfg_valid;
    logic took;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      idle_left = 0;
      quiet_cnt = 0;
    end else begin
      nx_start = start_i;
      nx_cfg_valid = cfg_valid_i;
      took = start_i && !busy_o;
      if (took) begin
        apply_cmd(cur_cmd);
        nx_start = 1'b0;
        if (idle_mode && cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < 35)
          idle_left = $urandom_range(1, 17);
        if ($urandom_range(0, 39) == 0) idle_mode = !idle_mode;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ref_len = cfg_data_i;
        nx_cfg_valid = 1'b0;
      end
      // a register write waits for the block to go quiet for a while
      if (took || busy_o || exp_results_q.size() != 0) quiet_cnt = 0;
      else if (quiet_cnt < QUIET_CYCLES) quiet_cnt++;
      if (!nx_start && !nx_cfg_valid) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (cmd_q.size() != 0) begin
          if (cmd_q[0].is_cfg) begin
            if (quiet_cnt >= QUIET_CYCLES) begin
              nx_cfg_valid = 1'b1;
              cfg_data_i <= cmd_q[0].len;
              cmd_q.pop_front();
            end
          end else begin
            cur_cmd = cmd_q.pop_front();
            nx_start = 1'b1;
            func_i <= cur_cmd.func;
            entry_index_i <= cur_cmd.idx;
            data_word_i <= cur_cmd.word;
          end
        end
      end
      start_i <= nx_start;
      cfg_valid_i <= nx_cfg_valid;
    end
  end

  // monitor
  search_result_t mon_exp;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (exp_results_q.size() == 0) begin
        $display("%0t: result with no query pending: expected none, actual count %0d matched %0b",
                 $time, compare_count_o, matched_o);
        err_cnt++;
      end else begin
        mon_exp = exp_results_q.pop_front();
        if (compare_count_o !== mon_exp.count) begin
          $display("%0t: compare_count mismatch: expected %0d, actual %0d",
                   $time, mon_exp.count, compare_count_o);
          err_cnt++;
        end
        if (matched_o !== mon_exp.matched) begin
          $display("%0t: matched mismatch: expected %0b, actual %0b",
                   $time, mon_exp.matched, matched_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic signed [WORD_W-1:0] vals [DEPTH];
    logic signed [WORD_W-1:0] t;
    logic signed [WORD_W-1:0] tmp;
    int                       phase;
    int                       len;
    int                       eff;
    int                       nq;
    int                       i;
    int                       j;
    int                       k;
    int                       r;
    int                       idx;
    bit                       need;
    bit                       sorted;
    bit                       narrow;

    // empty table: both searches answer at once
    push_cfg(0);
    push_query(FUNC_BINARY, 0);
    push_query(FUNC_LINEAR, -1);
    push_noise();

    // ascending entries with both word extremes, plus the top index
    vals[0] = 32'h8000_0000;
    vals[1] = -5;
    vals[2] = 0;
    vals[3] = 1;
    vals[4] = 7;
    vals[5] = 100;
    vals[6] = 32'h7FFF_FFFE;
    vals[7] = 32'h7FFF_FFFF;
    for (i = 0; i < 8; i++) push_write(i, vals[i], 1'b0);
    push_write(DEPTH - 1, 32'h5555_AAAA, 1'b0);
    push_cfg(8);
    push_query(FUNC_BINARY, 32'h8000_0000);
    push_query(FUNC_BINARY, 32'h7FFF_FFFF);
    push_query(FUNC_BINARY, 3);
    push_query(FUNC_BINARY, 100);
    push_query(FUNC_LINEAR, 32'h7FFF_FFFF);
    push_query(FUNC_LINEAR, 2);
    push_query(FUNC_LINEAR, 32'h8000_0000);
    push_cfg(1);
    push_query(FUNC_BINARY, -5);
    push_query(FUNC_LINEAR, 32'h8000_0000);

    phase = 0;
    while (gen_items < ITEM_TARGET) begin
      if (phase == 1) begin
        len = DEPTH;
      end else if (phase == 4) begin
        len = 2047;
      end else if (phase > 4 && $urandom_range(0, 49) == 0) begin
        len = $urandom_range(1000, 2047);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) len = 0;
        else if (r < 12) len = $urandom_range(49, 200);
        else len = $urandom_range(1, 48);
      end
      eff = (len > DEPTH) ? DEPTH : len;
      push_cfg(len);

      need = 1'b0;
      for (i = 0; i < eff; i++) if (!gen_written[i]) need = 1'b1;
      if (need || (eff <= 200 && $urandom_range(0, 4) != 0)) begin
        if (eff > 200) begin
          // strictly ascending across the whole word range
          for (i = 0; i < eff; i++)
            vals[i] = 32'h8000_0000 + (i << 22) + $urandom_range(0, 4194303);
        end else begin
          sorted = ($urandom_range(0, 3) != 0);
          narrow = ($urandom_range(0, 2) == 0);
          for (i = 0; i < eff; i++) begin
            if (narrow) begin
              vals[i] = $urandom_range(0, 40);
              vals[i] = vals[i] - 20;
            end else begin
              vals[i] = $urandom();
            end
          end
          if (sorted) begin
            for (i = 1; i < eff; i++) begin
              tmp = vals[i];
              j = i - 1;
              while (j >= 0 && vals[j] > tmp) begin
                vals[j + 1] = vals[j];
                j--;
              end
              vals[j + 1] = tmp;
            end
          end
        end
        for (i = 0; i < eff; i++) push_write(i, vals[i], eff > 200);
      end

      // stray writes above the searched range
      if (eff < DEPTH) begin
        for (k = $urandom_range(0, 3); k > 0; k--) begin
          idx = $urandom_range(eff, DEPTH - 1);
          push_write(idx, $urandom(), 1'b0);
        end
      end

      nq = (eff > 200) ? $urandom_range(2, 4) : $urandom_range(4, 20);
      for (k = 0; k < nq; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          push_noise();
        end else if (r < 10 && eff > 0) begin
          push_write($urandom_range(0, eff - 1), $urandom(), 1'b0);
        end else begin
          r = $urandom_range(0, 99);
          if (eff == 0 || r >= 85) t = $urandom();
          else if (r < 50) t = gen_tbl[$urandom_range(0, eff - 1)];
          else if (r < 75) t = gen_tbl[$urandom_range(0, eff - 1)] + ($urandom_range(0, 1) ? 1 : -1);
          else if (r < 80) t = 32'h8000_0000;
          else t = 32'h7FFF_FFFF;
          push_query($urandom_range(0, 1) ? FUNC_BINARY : FUNC_LINEAR, t);
        end
      end
      phase++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start_i || cfg_valid_i) @(posedge clk_i);
    while (exp_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
